FILE: rtl/mks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and helpers of the debounced matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

  localparam int ROWS       = 4;
  localparam int COLUMNS    = 4;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int SCAN_ROWS  = (ROWS < 4) ? ROWS : 4;
  localparam int KEYS       = 16;

  localparam int CNT_W      = 20;
  localparam int CODE_W     = 8;
  localparam int LINES      = 4;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(50000);
  localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_MAP_LOW  = 2'd1;
  localparam logic [1:0] REG_MAP_HIGH = 2'd2;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [63:0]      key_map_low;
    logic [63:0]      key_map_high;
  } cfg_t;

  typedef struct packed {
    logic [LINES-1:0]  column_drive;
    logic              scan_done;
    logic              key_found;
    logic [CODE_W-1:0] key_code;
  } res_t;

  function automatic logic [LINES-1:0] drive_for(input logic [COL_W-1:0] col);
    logic [LINES-1:0] d;
    d = {LINES{1'b1}};
    for (int i = 0; i < LINES; i++) begin
      if (int'(col) == i) begin
        d[i] = 1'b0;
      end
    end
    return d;
  endfunction

  function automatic logic row_low(input logic [LINES-1:0] rows,
                                   input logic [ROW_W-1:0] r);
    logic low;
    low = 1'b0;
    for (int i = 0; i < SCAN_ROWS; i++) begin
      if (int'(r) == i) begin
        low = !rows[i];
      end
    end
    return low;
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col,
                                                input logic [63:0] map_low,
                                                input logic [63:0] map_high);
    logic [127:0]      map;
    logic [CODE_W-1:0] code;
    int                idx;
    map  = {map_high, map_low};
    idx  = int'(row) * COLUMNS + int'(col);
    code = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (idx == k) begin
        code = map[CODE_W*k +: CODE_W];
      end
    end
    return code;
  endfunction

endpackage

FILE: rtl/mks_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_in_if
// Input channel: one item carries the sampled row levels.
// ----------------------------------------------------------------------------
interface mks_in_if;
  logic                    valid;
  logic                    ready;
  logic [mks_pkg::LINES-1:0] row_levels;

  modport source (output valid, output row_levels, input ready);
  modport sink   (input valid, input row_levels, output ready);
endinterface

FILE: rtl/mks_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_out_if
// Result channel: column drive and end-of-pass report.
// ----------------------------------------------------------------------------
interface mks_out_if;
  logic                       valid;
  logic                       ready;
  logic [mks_pkg::LINES-1:0]  column_drive;
  logic                       scan_done;
  logic                       key_found;
  logic [mks_pkg::CODE_W-1:0] key_code;

  modport source (output valid, output column_drive, output scan_done,
                  output key_found, output key_code, input ready);
  modport sink   (input valid, input column_drive, input scan_done,
                  input key_found, input key_code, output ready);
endinterface

FILE: rtl/mks_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_cfg
// APB register file: debounce time and the two halves of the key map.
// ----------------------------------------------------------------------------
module mks_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mks_pkg::ADDR_W-1:0]  paddr,
  input  logic [mks_pkg::DATA_W-1:0]  pwdata,
  output logic [mks_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mks_pkg::cfg_t               cfg
);

  mks_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= mks_pkg::DEBOUNCE_RESET;
      cfg_r.key_map_low    <= '0;
      cfg_r.key_map_high   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        mks_pkg::REG_DEBOUNCE: cfg_r.debounce_ticks <= pwdata[mks_pkg::CNT_W-1:0];
        mks_pkg::REG_MAP_LOW:  cfg_r.key_map_low    <= pwdata;
        mks_pkg::REG_MAP_HIGH: cfg_r.key_map_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mks_pkg::REG_DEBOUNCE: prdata = {{(mks_pkg::DATA_W-mks_pkg::CNT_W){1'b0}},
                                       cfg_r.debounce_ticks};
      mks_pkg::REG_MAP_LOW:  prdata = cfg_r.key_map_low;
      mks_pkg::REG_MAP_HIGH: prdata = cfg_r.key_map_high;
      default:               prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/mks_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_core
// Scan state and the one-tick update: row pick, debounce count, key record,
// release wait and column advance.
// ----------------------------------------------------------------------------
module mks_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [mks_pkg::LINES-1:0]  row_levels,
  input  mks_pkg::cfg_t              cfg,
  output mks_pkg::res_t              res
);

  logic [mks_pkg::COL_W-1:0]  column_r,    column_nxt;
  mks_pkg::phase_t            phase_r,     phase_nxt;
  logic [mks_pkg::CNT_W-1:0]  count_r,     count_nxt;
  logic [mks_pkg::ROW_W-1:0]  row_r,       row_nxt;
  logic                       found_r,     found_nxt;
  logic [mks_pkg::CODE_W-1:0] code_r,      code_nxt;
  logic                       advance;
  logic                       hit;
  logic [mks_pkg::ROW_W-1:0]  hit_row;

  // lowest low row
  always_comb begin
    hit     = 1'b0;
    hit_row = '0;
    for (int r = mks_pkg::SCAN_ROWS - 1; r >= 0; r--) begin
      if (!row_levels[r]) begin
        hit     = 1'b1;
        hit_row = mks_pkg::ROW_W'(r);
      end
    end
  end

  always_comb begin
    column_nxt = column_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    row_nxt    = row_r;
    found_nxt  = found_r;
    code_nxt   = code_r;
    advance    = 1'b0;
    res        = '0;

    case (phase_r)
      mks_pkg::PH_DEBOUNCE: begin
        if (count_r < cfg.debounce_ticks) begin
          if (count_r != mks_pkg::COUNT_MAX) begin
            count_nxt = count_r + 1'b1;
          end
        end else if (mks_pkg::row_low(row_levels, row_r)) begin
          found_nxt = 1'b1;
          code_nxt  = mks_pkg::code_of(row_r, column_r,
                                       cfg.key_map_low, cfg.key_map_high);
          phase_nxt = mks_pkg::PH_RELEASE;
        end else begin
          advance = 1'b1;
        end
      end
      mks_pkg::PH_RELEASE: begin
        advance = !mks_pkg::row_low(row_levels, row_r);
      end
      default: begin
        if (hit) begin
          row_nxt   = hit_row;
          count_nxt = '0;
          phase_nxt = mks_pkg::PH_DEBOUNCE;
        end else begin
          advance = 1'b1;
        end
      end
    endcase

    if (advance) begin
      phase_nxt = mks_pkg::PH_SCAN;
      if (int'(column_r) + 1 >= mks_pkg::COLUMNS) begin
        res.scan_done = 1'b1;
        res.key_found = found_r;
        res.key_code  = found_r ? code_r : '0;
        found_nxt     = 1'b0;
        code_nxt      = '0;
        column_nxt    = '0;
      end else begin
        column_nxt = column_r + 1'b1;
      end
    end

    res.column_drive = mks_pkg::drive_for(column_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      phase_r  <= mks_pkg::PH_SCAN;
      count_r  <= '0;
      row_r    <= '0;
      found_r  <= 1'b0;
      code_r   <= '0;
    end else if (step) begin
      column_r <= column_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      row_r    <= row_nxt;
      found_r  <= found_nxt;
      code_r   <= code_nxt;
    end
  end

  a_release_no_debounce: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == mks_pkg::PH_RELEASE |=> phase_r != mks_pkg::PH_DEBOUNCE)
    else $error("release phase went straight to debounce");

  a_done_clears_found: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.scan_done |=> !found_r && code_r == '0 && column_r == '0)
    else $error("pass end did not clear the recorded key");

  a_hold_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(column_r) && $stable(phase_r) && $stable(count_r))
    else $error("scan state moved without an item");

endmodule

FILE: rtl/matrix_keypad_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Debounced 4x4 matrix keypad scanner with APB configuration.
// ----------------------------------------------------------------------------
// Each input item is one sampling tick of the row pins, taken under the column
// drive of the previous result (column 0 low after reset). Every item gives
// exactly one result: the column drive for the next tick and, at the end of a
// pass over all columns, the found flag and last recorded key code. The scan
// state updates in the cycle the item is accepted and the result lands in a
// single output register, so a new item is accepted every cycle while that
// register is empty or being drained.
// Registers: debounce_ticks at 0x00, key_map_low at 0x08, key_map_high at 0x10.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner (
  input  logic                        clk,
  input  logic                        rst_n,
  mks_in_if.sink                      in_if,
  mks_out_if.source                   out_if,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mks_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [mks_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [mks_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  mks_pkg::cfg_t cfg;
  mks_pkg::res_t res;
  mks_pkg::res_t out_res_r;
  logic          out_valid_r;
  logic          step;

  mks_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mks_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .row_levels (in_if.row_levels),
    .cfg        (cfg),
    .res        (res)
  );

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign step        = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.column_drive = out_res_r.column_drive;
  assign out_if.scan_done    = out_res_r.scan_done;
  assign out_if.key_found    = out_res_r.key_found;
  assign out_if.key_code     = out_res_r.key_code;

endmodule

FILE: verif/matrix_keypad_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_tb
// Self-checking bench for the debounced keypad scanner. A scoreboard keeps its
// own copy of the scan state and the registers, predicts the result of every
// row sample it sees accepted, and compares the results in order. Stimulus
// runs a short directed sequence, then a virtual keypad whose held keys are
// read under the column drive the block asks for, mixed with bounce and noise.
// Both channels idle at random, and the registers change between phases.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_tb;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 300000;

  class keypad_scoreboard;
    logic [mks_pkg::CNT_W-1:0]   dticks;
    logic [63:0]                 map_lo;
    logic [63:0]                 map_hi;
    logic [mks_pkg::COL_W-1:0]   col;
    mks_pkg::phase_t             phase;
    logic [mks_pkg::CNT_W-1:0]   count;
    logic [mks_pkg::ROW_W-1:0]   row_sel;
    logic                        have_key;
    logic [mks_pkg::CODE_W-1:0]  key;
    mks_pkg::res_t               drive_reports[$];
    int                          errors;

    function new();
      dticks   = mks_pkg::DEBOUNCE_RESET;
      map_lo   = '0;
      map_hi   = '0;
      col      = '0;
      phase    = mks_pkg::PH_SCAN;
      count    = '0;
      row_sel  = '0;
      have_key = 1'b0;
      key      = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        mks_pkg::REG_DEBOUNCE: dticks = value[mks_pkg::CNT_W-1:0];
        mks_pkg::REG_MAP_LOW:  map_lo = value;
        mks_pkg::REG_MAP_HIGH: map_hi = value;
        default: ;
      endcase
    endfunction

    function logic [mks_pkg::CODE_W-1:0] key_code_at(logic [mks_pkg::ROW_W-1:0] r,
                                                     logic [mks_pkg::COL_W-1:0] c);
      logic [127:0] codes;
      int           idx;
      codes = {map_hi, map_lo};
      idx   = int'(r) * mks_pkg::COLUMNS + int'(c);
      return codes[mks_pkg::CODE_W*idx +: mks_pkg::CODE_W];
    endfunction

    function void note_tick(logic [mks_pkg::LINES-1:0] rows);
      mks_pkg::res_t r;
      logic          step_on;
      r       = '0;
      step_on = 1'b0;
      case (phase)
        mks_pkg::PH_DEBOUNCE: begin
          if (count < dticks) begin
            if (count != mks_pkg::COUNT_MAX) count++;
          end else if (!rows[row_sel]) begin
            have_key = 1'b1;
            key      = key_code_at(row_sel, col);
            phase    = mks_pkg::PH_RELEASE;
          end else begin
            step_on = 1'b1;
          end
        end
        mks_pkg::PH_RELEASE: begin
          if (rows[row_sel]) step_on = 1'b1;
        end
        default: begin
          step_on = 1'b1;
          for (int i = 0; i < mks_pkg::SCAN_ROWS; i++) begin
            if (step_on && !rows[i]) begin
              row_sel = mks_pkg::ROW_W'(i);
              count   = '0;
              phase   = mks_pkg::PH_DEBOUNCE;
              step_on = 1'b0;
            end
          end
        end
      endcase
      if (step_on) begin
        phase = mks_pkg::PH_SCAN;
        if (int'(col) == mks_pkg::COLUMNS - 1) begin
          r.scan_done = 1'b1;
          r.key_found = have_key;
          r.key_code  = have_key ? key : '0;
          have_key    = 1'b0;
          key         = '0;
          col         = '0;
        end else begin
          col++;
        end
      end
      r.column_drive = ~(mks_pkg::LINES'(1) << col);
      drive_reports.push_back(r);
    endfunction

    function void check_result(mks_pkg::res_t got);
      mks_pkg::res_t want;
      if (drive_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = drive_reports.pop_front();
      if (got.column_drive !== want.column_drive || got.scan_done !== want.scan_done ||
          got.key_found !== want.key_found || got.key_code !== want.key_code) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: drive %h/%h done %b/%b found %b/%b",
                    " code %h/%h (exp/act)"},
                   want.column_drive, got.column_drive, want.scan_done, got.scan_done,
                   want.key_found, got.key_found, want.key_code, got.key_code);
      end
    endfunction

    function int pending();
      return drive_reports.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [mks_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [mks_pkg::DATA_W-1:0]   cfg_pwdata;
  logic [mks_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  mks_in_if  in_ch();
  mks_out_if out_ch();

  keypad_scoreboard sb;
  logic [15:0]      held_keys;
  bit               gaps_on;
  bit               noise_on;

  matrix_keypad_scanner DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_tick(in_ch.row_levels);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.column_drive, out_ch.scan_done,
                        out_ch.key_found, out_ch.key_code});
  end

  // receiver stall pattern, reshuffled whenever stall_cnt runs out
  initial begin
    logic [15:0] stall_pat;
    int          stall_cnt;
    bit          free_run;
    stall_cnt    = 0;
    stall_pat    = '1;
    free_run     = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cnt == 0) begin
        stall_cnt = 64;
        free_run  = ($urandom_range(0, 2) == 0);
        stall_pat = 16'($urandom);
      end
      stall_cnt--;
      out_ch.ready <= free_run || stall_pat[stall_cnt % 16];
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("matrix_keypad_scanner: mismatch");
    $finish;
  end

  function automatic logic [3:0] rows_for(logic [15:0] keys,
                                          logic [mks_pkg::COL_W-1:0] c);
    logic [3:0] v;
    v = '1;
    for (int r = 0; r < 4; r++) begin
      if (keys[r*4 + int'(c)]) v[r] = 1'b0;
    end
    return v;
  endfunction

  // hold the item until accepted; leave valid high for the caller
  task automatic send_item(logic [3:0] rows);
    in_ch.valid      <= 1'b1;
    in_ch.row_levels <= rows;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= mks_pkg::ADDR_W'({idx, 3'b000});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_keypad(int n_items);
    int         sent;
    int         burst;
    int         hold;
    int         d;
    int         pick;
    logic [3:0] rows;
    sent  = 0;
    burst = 0;
    hold  = 0;
    while (sent < n_items) begin
      if (burst == 0) begin
        if (gaps_on) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        burst    = $urandom_range(1, 40);
        noise_on = ($urandom_range(0, 9) == 0);
      end
      if (hold == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) held_keys = '0;
        else if (pick < 8) held_keys = 16'(1) << $urandom_range(0, 15);
        else if (pick == 8)
          held_keys = (16'(1) << $urandom_range(0, 15)) | (16'(1) << $urandom_range(0, 15));
        else held_keys = 16'($urandom);
        d    = (sb.dticks > 30) ? 30 : int'(sb.dticks);
        hold = $urandom_range(1, 4 * (d + 3) + 8);
      end
      rows = rows_for(held_keys, sb.col);
      if ($urandom_range(0, 15) == 0) rows ^= 4'(1) << $urandom_range(0, 3);
      if (noise_on) rows = 4'($urandom);
      send_item(rows);
      sent++;
      burst--;
      hold--;
    end
  endtask

  initial begin
    logic [mks_pkg::CNT_W-1:0] d;
    sb               = new();
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.row_levels = 4'hF;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    held_keys        = '0;
    gaps_on          = 1'b1;
    noise_on         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset registers: empty pass, then a key stuck in a long debounce
    repeat (4) send_item(4'hF);
    repeat (4) send_item(4'h0);
    drain();
    // lower the debounce below the running count: resample on the next tick
    reg_write(mks_pkg::REG_DEBOUNCE, 64'd0);
    send_item(4'h0);
    send_item(4'h0);
    send_item(4'hE);
    send_item(4'hF);
    drain();
    reg_write(mks_pkg::REG_MAP_LOW,  64'hF7E6_D5C4_B3A2_9180);
    reg_write(mks_pkg::REG_MAP_HIGH, 64'h0F1E_2D3C_4B5A_6978);
    // column 1 records row 3, column 2 bounces, column 3 records row 0
    send_item(4'h7);
    send_item(4'h7);
    send_item(4'hF);
    send_item(4'hD);
    send_item(4'hF);
    send_item(4'h8);
    send_item(4'h8);
    send_item(4'hF);
    drain();
    reg_write(mks_pkg::REG_DEBOUNCE, 64'hF_FFFF);
    repeat (6) send_item(4'hB);
    drain();
    reg_write(mks_pkg::REG_DEBOUNCE, 64'd2);
    repeat (3) send_item(4'hB);
    send_item(4'hF);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: d = 0;
        1: d = 1;
        2: d = 3;
        4: d = 20;
        5: d = 0;
        default: d = mks_pkg::CNT_W'($urandom_range(0, 8));
      endcase
      reg_write(mks_pkg::REG_DEBOUNCE, 64'(d));
      if (p == 0) begin
        reg_write(mks_pkg::REG_MAP_LOW,  '1);
        reg_write(mks_pkg::REG_MAP_HIGH, '1);
      end else if (p == 5) begin
        reg_write(mks_pkg::REG_MAP_LOW,  '0);
        reg_write(mks_pkg::REG_MAP_HIGH, '0);
      end else begin
        reg_write(mks_pkg::REG_MAP_LOW,  {32'($urandom), 32'($urandom)});
        reg_write(mks_pkg::REG_MAP_HIGH, {32'($urandom), 32'($urandom)});
      end
      gaps_on = (p % 3 != 2);
      run_keypad(140);
      drain();
    end

    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("matrix_keypad_scanner: match");
    end else begin
      $display("matrix_keypad_scanner: mismatch");
    end
    $finish;
  end

endmodule
